// ===== hdl/naia_pkg.sv =====
// shared types, constants and codes for the near address interval allocator
`default_nettype none
package naia_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = IDX_W + 1;
   localparam int ADDR_W        = 48;
   localparam int SIZE_W        = 32;
   localparam int SHIFT_W       = 5;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLE_LIMIT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_CAP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT   = 3'd4;

   localparam logic [SIZE_W-1:0]  CHUNK_SIZE_RST   = 32'd16777216;
   localparam logic [ADDR_W-1:0]  HOLE_LIMIT_RST   = 48'd1610612736;
   localparam logic [ADDR_W-1:0]  MAX_DISTANCE_RST = 48'd1610612736;
   localparam logic [SIZE_W-1:0]  SIZE_CAP_RST     = 32'd2147483646;
   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST   = 5'd12;

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_ADD_HOLE = 2'd1,
      OP_ALLOCATE = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_FIT     = 2'd1,
      STAT_FULL       = 2'd2,
      STAT_EMPTY_HOLE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HOLE_PREP,
      S_HOLE_FILL,
      S_ALLOC,
      S_GRANT,
      S_RESP
   } state_type;

   typedef struct packed {
      op_type            operation;
      logic [ADDR_W-1:0] hole_start;
      logic [ADDR_W-1:0] hole_end;
      logic [ADDR_W-1:0] request_address;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] alloc_base;
      logic [SIZE_W-1:0] alloc_size;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
      logic              used;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [SIZE_W-1:0]  size_cap;
      logic [SHIFT_W-1:0] page_shift;
   } grant_cfg_type;

   typedef struct packed {
      logic              vld;
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
   } grant_in_type;

   typedef struct packed {
      logic              vld;
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] size;
   } grant_out_type;

endpackage
`default_nettype wire

// ===== hdl/naia_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module naia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/naia_grant.sv =====
// pipelined size capping, page rounding and base computation for a granted interval
`default_nettype none
module naia_grant (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire naia_pkg::grant_cfg_type cfg,
   input  wire naia_pkg::grant_in_type  grant_in,
   output naia_pkg::grant_out_type      grant_out
);

   logic                          s1_vld_ff, s1_vld_in;
   logic [naia_pkg::SIZE_W-1:0]   s1_size_ff, s1_size_in;
   logic [naia_pkg::ADDR_W-1:0]   s1_end_ff;
   logic                          s2_vld_ff, s2_vld_in;
   logic [naia_pkg::SIZE_W-1:0]   s2_size_ff, s2_size_in;
   logic [naia_pkg::SIZE_W-1:0]   s2_ps_ff, s2_ps_in;
   logic [naia_pkg::ADDR_W-1:0]   s2_end_ff;
   logic                          s3_vld_ff;
   logic [naia_pkg::SIZE_W-1:0]   s3_size_ff;
   logic [naia_pkg::SIZE_W-1:0]   s3_ps_ff;
   logic [naia_pkg::ADDR_W-1:0]   s3_base_ff, s3_base_in;
   logic                          out_vld_ff;
   logic [naia_pkg::ADDR_W-1:0]   out_base_ff, out_base_in;
   logic [naia_pkg::SIZE_W-1:0]   out_size_ff, out_size_in;

   logic [naia_pkg::ADDR_W-1:0]   diff;
   logic [naia_pkg::SIZE_W:0]     ps_wide;
   logic [naia_pkg::SIZE_W:0]     mask_wide;
   logic [naia_pkg::SIZE_W:0]     round_wide;
   logic [naia_pkg::SIZE_W:0]     sat_wide;
   logic                          below_page;

   // stage 1: interval length and cap
   always_comb begin
      diff       = grant_in.end_addr - grant_in.start_addr;
      s1_vld_in  = grant_in.vld;
      s1_size_in = (diff > naia_pkg::ADDR_W'(cfg.size_cap)) ? cfg.size_cap
                                                           : diff[naia_pkg::SIZE_W-1:0];
   end

   // stage 2: round up to a page, saturate to the largest page multiple
   always_comb begin
      ps_wide    = (naia_pkg::SIZE_W+1)'(1) << cfg.page_shift;
      mask_wide  = ps_wide - (naia_pkg::SIZE_W+1)'(1);
      round_wide = ({1'b0, s1_size_ff} + mask_wide) & ~mask_wide;
      sat_wide   = {1'b1, {naia_pkg::SIZE_W{1'b0}}} - ps_wide;
      s2_vld_in  = s1_vld_ff;
      s2_ps_in   = ps_wide[naia_pkg::SIZE_W-1:0];
      s2_size_in = round_wide[naia_pkg::SIZE_W] ? sat_wide[naia_pkg::SIZE_W-1:0]
                                                : round_wide[naia_pkg::SIZE_W-1:0];
   end

   // stage 3: base below the end
   assign s3_base_in = s2_end_ff - naia_pkg::ADDR_W'(s2_size_ff);

   // stage 4: keep the base off the first page
   always_comb begin
      below_page  = s3_base_ff < naia_pkg::ADDR_W'(s3_ps_ff);
      out_base_in = s3_base_ff;
      out_size_in = s3_size_ff;
      if (below_page) begin
         out_base_in = s3_base_ff + naia_pkg::ADDR_W'(s3_ps_ff);
         out_size_in = (s3_size_ff >= s3_ps_ff) ? s3_size_ff - s3_ps_ff
                                                : {naia_pkg::SIZE_W{1'b0}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s2_vld_ff;
         out_vld_ff <= s3_vld_ff;
      end
      s1_size_ff  <= s1_size_in;
      s1_end_ff   <= grant_in.end_addr;
      s2_size_ff  <= s2_size_in;
      s2_ps_ff    <= s2_ps_in;
      s2_end_ff   <= s1_end_ff;
      s3_size_ff  <= s2_size_ff;
      s3_ps_ff    <= s2_ps_ff;
      s3_base_ff  <= s3_base_in;
      out_base_ff <= out_base_in;
      out_size_ff <= out_size_in;
   end

   assign grant_out.vld  = out_vld_ff;
   assign grant_out.base = out_base_ff;
   assign grant_out.size = out_size_ff;

endmodule
`default_nettype wire

// ===== hdl/near_address_interval_allocator.sv =====
// top level: interval table sequencer with table ram and grant pipeline
//
// Keeps a table of free address intervals in a 256-entry ram and answers one
// request at a time on the req_ channel with exactly one response on rsp_.
// operation clear empties the table, add hole cuts a hole into chunk-sized
// entries appended at the table tail, allocate takes the first unused entry
// within max_distance below request_address and grants a page-rounded region.
// Path from request accept to the response register:
//   clear or unknown operation: straight to the response
//   add hole: a prep state, one table write per chunk, then the response; a
//   full table stops the writes and answers with status full
//   allocate: the table ram reads one entry per cycle up to the table count,
//   then the first hit goes through a 4-stage grant pipe; a miss answers no fit
// The next request is taken in the cycle after the response register is loaded;
// one response may wait under rsp_stall while the next request is already
// in work, and a request that finishes while the response register is still
// held waits in its last state.
// csr_ writes take effect at once and are expected only while no request is in work.
// Synchronous reset empties the table (count to zero) and restores settings.
`default_nettype none
module near_address_interval_allocator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire naia_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output naia_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [naia_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [naia_pkg::CSR_DATA_W-1:0] csr_wdata
);

   naia_pkg::state_type           state_ff, state_in;
   logic [naia_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [naia_pkg::CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [naia_pkg::IDX_W-1:0]    chk_idx_ff, chk_idx_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   naia_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   naia_pkg::rsp_type             res_ff, res_in;
   logic [naia_pkg::ADDR_W-1:0]   hole_start_ff, hole_start_in;
   logic [naia_pkg::ADDR_W-1:0]   hole_end_ff, hole_end_in;
   logic [naia_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [naia_pkg::ADDR_W-1:0]   lo_ff, lo_in;
   logic [naia_pkg::ADDR_W-1:0]   cur_ff, cur_in;
   logic [naia_pkg::ADDR_W-1:0]   rem_ff, rem_in;

   logic [naia_pkg::SIZE_W-1:0]   chunk_size_ff;
   logic [naia_pkg::ADDR_W-1:0]   hole_limit_ff;
   logic [naia_pkg::ADDR_W-1:0]   max_distance_ff;
   logic [naia_pkg::SIZE_W-1:0]   size_cap_ff;
   logic [naia_pkg::SHIFT_W-1:0]  page_shift_ff;

   logic                          ram_wr_en;
   logic [naia_pkg::IDX_W-1:0]    ram_wr_addr;
   naia_pkg::entry_type           ram_wr_entry;
   logic                          ram_rd_en;
   logic [naia_pkg::ENTRY_W-1:0]  ram_rd_data;
   naia_pkg::entry_type           rd_entry;

   naia_pkg::grant_cfg_type       grant_cfg;
   naia_pkg::grant_in_type        grant_in;
   naia_pkg::grant_out_type       grant_out;

   logic                          slot_free;
   logic [naia_pkg::ADDR_W-1:0]   hole_len;
   logic                          hole_over;
   logic                          hole_empty;
   logic                          table_full;
   logic                          split;
   logic                          issue;
   logic                          hit;

   assign rd_entry  = naia_pkg::entry_type'(ram_rd_data);
   assign slot_free = !rsp_vld_ff || !rsp_stall;
   assign req_stall = (state_ff != naia_pkg::S_IDLE);

   assign grant_cfg.size_cap   = size_cap_ff;
   assign grant_cfg.page_shift = page_shift_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      res_in        = res_ff;
      hole_start_in = hole_start_ff;
      hole_end_in   = hole_end_ff;
      addr_in       = addr_ff;
      lo_in         = lo_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      rsp_vld_in    = rsp_vld_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[naia_pkg::IDX_W-1:0];
      ram_wr_entry  = '{start_addr: cur_ff, end_addr: hole_end_ff, used: 1'b0};
      ram_rd_en     = 1'b0;

      grant_in.vld        = 1'b0;
      grant_in.start_addr = rd_entry.start_addr;
      grant_in.end_addr   = rd_entry.end_addr;

      hole_len   = hole_end_ff - hole_start_ff;
      hole_over  = hole_len > hole_limit_ff;
      hole_empty = (hole_end_ff <= hole_start_ff)
                   || (hole_over && (hole_limit_ff == {naia_pkg::ADDR_W{1'b0}}));
      table_full = count_ff >= naia_pkg::CNT_W'(naia_pkg::TABLE_ENTRIES);
      split      = (chunk_size_ff != {naia_pkg::SIZE_W{1'b0}})
                   && (rem_ff > naia_pkg::ADDR_W'(chunk_size_ff));
      issue      = scan_idx_ff < count_ff;
      hit        = chk_vld_ff && !rd_entry.used && (rd_entry.start_addr <= addr_ff)
                   && (rd_entry.start_addr >= lo_ff);

      unique case (state_ff)
         naia_pkg::S_IDLE: begin
            if (req_valid) begin
               hole_start_in      = req_data.hole_start;
               hole_end_in        = req_data.hole_end;
               addr_in            = req_data.request_address;
               lo_in              = (max_distance_ff > req_data.request_address)
                                    ? {naia_pkg::ADDR_W{1'b0}}
                                    : req_data.request_address - max_distance_ff;
               res_in.status      = naia_pkg::STAT_OK;
               res_in.alloc_base  = {naia_pkg::ADDR_W{1'b0}};
               res_in.alloc_size  = {naia_pkg::SIZE_W{1'b0}};
               scan_idx_in        = {naia_pkg::CNT_W{1'b0}};
               unique case (req_data.operation)
                  naia_pkg::OP_CLEAR: begin
                     count_in = {naia_pkg::CNT_W{1'b0}};
                     state_in = naia_pkg::S_RESP;
                  end
                  naia_pkg::OP_ADD_HOLE: begin
                     state_in = naia_pkg::S_HOLE_PREP;
                  end
                  naia_pkg::OP_ALLOCATE: begin
                     state_in = naia_pkg::S_ALLOC;
                  end
                  default: begin
                     state_in = naia_pkg::S_RESP;
                  end
               endcase
            end
         end
         naia_pkg::S_HOLE_PREP: begin
            cur_in = hole_over ? hole_end_ff - hole_limit_ff : hole_start_ff;
            rem_in = hole_over ? hole_limit_ff : hole_len;
            if (hole_empty) begin
               res_in.status = naia_pkg::STAT_EMPTY_HOLE;
               state_in      = naia_pkg::S_RESP;
            end else begin
               state_in = naia_pkg::S_HOLE_FILL;
            end
         end
         naia_pkg::S_HOLE_FILL: begin
            if (table_full) begin
               res_in.status = naia_pkg::STAT_FULL;
               state_in      = naia_pkg::S_RESP;
            end else begin
               ram_wr_en = 1'b1;
               if (split) begin
                  ram_wr_entry.end_addr = cur_ff + naia_pkg::ADDR_W'(chunk_size_ff);
               end
               count_in = count_ff + 1'b1;
               cur_in   = ram_wr_entry.end_addr;
               rem_in   = rem_ff - naia_pkg::ADDR_W'(chunk_size_ff);
               if (!split) begin
                  state_in = naia_pkg::S_RESP;
               end
            end
         end
         naia_pkg::S_ALLOC: begin
            if (hit) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = chk_idx_ff;
               ram_wr_entry = '{start_addr: rd_entry.start_addr,
                                end_addr: rd_entry.end_addr, used: 1'b1};
               grant_in.vld = 1'b1;
               state_in     = naia_pkg::S_GRANT;
            end else if (issue) begin
               ram_rd_en   = 1'b1;
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_idx_ff[naia_pkg::IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end else if (!chk_vld_ff) begin
               res_in.status = naia_pkg::STAT_NO_FIT;
               state_in      = naia_pkg::S_RESP;
            end
         end
         naia_pkg::S_GRANT: begin
            if (grant_out.vld) begin
               res_in.alloc_base = grant_out.base;
               res_in.alloc_size = grant_out.size;
               state_in          = naia_pkg::S_RESP;
            end
         end
         naia_pkg::S_RESP: begin
            if (slot_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = res_ff;
               state_in    = naia_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = naia_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= naia_pkg::S_IDLE;
         count_ff        <= {naia_pkg::CNT_W{1'b0}};
         scan_idx_ff     <= {naia_pkg::CNT_W{1'b0}};
         chk_vld_ff      <= 1'b0;
         rsp_vld_ff      <= 1'b0;
         chunk_size_ff   <= naia_pkg::CHUNK_SIZE_RST;
         hole_limit_ff   <= naia_pkg::HOLE_LIMIT_RST;
         max_distance_ff <= naia_pkg::MAX_DISTANCE_RST;
         size_cap_ff     <= naia_pkg::SIZE_CAP_RST;
         page_shift_ff   <= naia_pkg::PAGE_SHIFT_RST;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         scan_idx_ff <= scan_idx_in;
         chk_vld_ff  <= chk_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               naia_pkg::CSR_CHUNK_SIZE:   chunk_size_ff   <= csr_wdata[naia_pkg::SIZE_W-1:0];
               naia_pkg::CSR_HOLE_LIMIT:   hole_limit_ff   <= csr_wdata[naia_pkg::ADDR_W-1:0];
               naia_pkg::CSR_MAX_DISTANCE: max_distance_ff <= csr_wdata[naia_pkg::ADDR_W-1:0];
               naia_pkg::CSR_SIZE_CAP:     size_cap_ff     <= csr_wdata[naia_pkg::SIZE_W-1:0];
               naia_pkg::CSR_PAGE_SHIFT:   page_shift_ff   <= csr_wdata[naia_pkg::SHIFT_W-1:0];
               default: begin
               end
            endcase
         end
      end
      chk_idx_ff    <= chk_idx_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
      hole_start_ff <= hole_start_in;
      hole_end_ff   <= hole_end_in;
      addr_ff       <= addr_in;
      lo_ff         <= lo_in;
      cur_ff        <= cur_in;
      rem_ff        <= rem_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   naia_ram #(
      .WIDTH(naia_pkg::ENTRY_W),
      .DEPTH(naia_pkg::TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff[naia_pkg::IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   naia_grant u_grant (
      .clock     (clock),
      .reset     (reset),
      .cfg       (grant_cfg),
      .grant_in  (grant_in),
      .grant_out (grant_out)
   );

   // table count never passes the table depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= naia_pkg::CNT_W'(naia_pkg::TABLE_ENTRIES))
      else $error("table count beyond depth");

   // table writes only while filling a hole or marking a hit
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == naia_pkg::S_HOLE_FILL || state_ff == naia_pkg::S_ALLOC))
      else $error("table write outside fill or allocate");

   // each chunk write grows the table by one
   assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == naia_pkg::S_HOLE_FILL)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("chunk write without count step");

   // grant results only come back while waiting for them
   assert property (@(posedge clock) disable iff (reset)
      grant_out.vld |-> state_ff == naia_pkg::S_GRANT)
      else $error("unexpected grant result");

endmodule
`default_nettype wire

// ===== tb/naia_checker.sv =====
`timescale 1ns / 1ps
// request and response monitor for the interval allocator: predicts each response and compares
module naia_checker
   import naia_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire req_type               req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire rsp_type               rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         outstanding,
   output int                         grant_count,
   output int                         miss_count,
   output int                         full_count,
   output int                         empty_hole_count
);

   localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_W) - 64'd1;

   logic [SIZE_W-1:0]  cfg_chunk;
   logic [ADDR_W-1:0]  cfg_hole_limit;
   logic [ADDR_W-1:0]  cfg_reach;
   logic [SIZE_W-1:0]  cfg_size_cap;
   logic [SHIFT_W-1:0] cfg_page_shift;

   logic [ADDR_W-1:0] free_lo [TABLE_ENTRIES];
   logic [ADDR_W-1:0] free_hi [TABLE_ENTRIES];
   bit                free_taken [TABLE_ENTRIES];
   int                free_count;

   rsp_type awaited_rsps[$];

   function automatic status_type append_hole(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      logic [ADDR_W-1:0] cur;
      logic [ADDR_W-1:0] piece_hi;
      bit                last;
      if (hi <= lo)
         return STAT_EMPTY_HOLE;
      if (hi - lo > cfg_hole_limit)
         lo = hi - cfg_hole_limit;
      if (hi <= lo)
         return STAT_EMPTY_HOLE;
      cur = lo;
      while (1) begin
         if (free_count >= TABLE_ENTRIES)
            return STAT_FULL;
         if (cfg_chunk != 0 && hi - cur > ADDR_W'(cfg_chunk)) begin
            piece_hi = cur + ADDR_W'(cfg_chunk);
            last = 1'b0;
         end else begin
            piece_hi = hi;
            last = 1'b1;
         end
         free_lo[free_count] = cur;
         free_hi[free_count] = piece_hi;
         free_taken[free_count] = 1'b0;
         free_count++;
         if (last)
            return STAT_OK;
         cur = piece_hi;
      end
   endfunction

   function automatic rsp_type grant_near(logic [ADDR_W-1:0] addr);
      rsp_type     res;
      logic [63:0] pg;
      logic [63:0] sz;
      logic [63:0] base;
      res = '0;
      res.status = STAT_NO_FIT;
      for (int i = 0; i < free_count; i++) begin
         if (free_lo[i] > addr || free_taken[i] || addr - free_lo[i] > cfg_reach)
            continue;
         free_taken[i] = 1'b1;
         pg = 64'd1 << cfg_page_shift;
         sz = 64'(free_hi[i] - free_lo[i]);
         if (sz > 64'(cfg_size_cap))
            sz = 64'(cfg_size_cap);
         sz = (sz + pg - 64'd1) & ~(pg - 64'd1);
         if (sz > 64'hFFFF_FFFF)
            sz = 64'h1_0000_0000 - pg;
         base = (64'(free_hi[i]) - sz) & ADDR_MASK;
         if (base < pg) begin
            base = (base + pg) & ADDR_MASK;
            sz = (sz >= pg) ? sz - pg : 64'd0;
         end
         res.status = STAT_OK;
         res.alloc_base = base[ADDR_W-1:0];
         res.alloc_size = sz[SIZE_W-1:0];
         return res;
      end
      return res;
   endfunction

   function automatic rsp_type model_request(req_type r);
      rsp_type res;
      res = '0;
      case (r.operation)
         OP_CLEAR:    free_count = 0;
         OP_ADD_HOLE: res.status = append_hole(r.hole_start, r.hole_end);
         OP_ALLOCATE: res = grant_near(r.request_address);
         default:     res.status = STAT_OK;
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         free_count = 0;
         cfg_chunk = CHUNK_SIZE_RST;
         cfg_hole_limit = HOLE_LIMIT_RST;
         cfg_reach = MAX_DISTANCE_RST;
         cfg_size_cap = SIZE_CAP_RST;
         cfg_page_shift = PAGE_SHIFT_RST;
         awaited_rsps.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               $error("response with no request outstanding: status %0d base 0x%0h size 0x%0h",
                      rsp_data.status, rsp_data.alloc_base, rsp_data.alloc_size);
               fail_count++;
            end else begin
               want = awaited_rsps.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("alloc_base", want.alloc_base, rsp_data.alloc_base);
               check_field("alloc_size", want.alloc_size, rsp_data.alloc_size);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CHUNK_SIZE:   cfg_chunk = csr_wdata[SIZE_W-1:0];
               CSR_HOLE_LIMIT:   cfg_hole_limit = csr_wdata[ADDR_W-1:0];
               CSR_MAX_DISTANCE: cfg_reach = csr_wdata[ADDR_W-1:0];
               CSR_SIZE_CAP:     cfg_size_cap = csr_wdata[SIZE_W-1:0];
               CSR_PAGE_SHIFT:   cfg_page_shift = csr_wdata[SHIFT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = model_request(req_data);
            awaited_rsps.insert(awaited_rsps.size(), want);
            case (want.status)
               STAT_OK:     if (req_data.operation == OP_ALLOCATE) grant_count++;
               STAT_NO_FIT: miss_count++;
               STAT_FULL:   full_count++;
               default:     empty_hole_count++;
            endcase
         end
      end
      outstanding = awaited_rsps.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top for the interval allocator: clock, reset, stimulus and final verdict
module tb_top;
   import naia_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 60;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int outstanding;
   int grant_count;
   int miss_count;
   int full_count;
   int empty_hole_count;
   int cycle_count;
   int items_sent;
   int settings_count;
   bit calm;
   bit pressure_go;

   logic [SIZE_W-1:0] cur_chunk;
   logic [ADDR_W-1:0] cur_limit;
   logic [ADDR_W-1:0] hole_lo_q[$];
   logic [ADDR_W-1:0] hole_hi_q[$];

   near_address_interval_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   naia_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .grant_count      (grant_count),
      .miss_count       (miss_count),
      .full_count       (full_count),
      .empty_hole_count (empty_hole_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** near_address_interval_allocator: FAILED **");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_go) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            pressure_go = 1'b0;
         end else
            rsp_stall <= !calm && ($urandom_range(99) < 27);
      end
   end

   function automatic logic [ADDR_W-1:0] rand48();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [ADDR_W-1:0] rand_scaled();
      return rand48() >> $urandom_range(47, 0);
   endfunction

   task automatic offer(input op_type op, input logic [ADDR_W-1:0] lo,
                        input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] addr);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{operation: op, hole_start: lo, hole_end: hi, request_address: addr};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [SIZE_W-1:0] chunk, input logic [ADDR_W-1:0] limit,
                                 input logic [ADDR_W-1:0] reach, input logic [SIZE_W-1:0] cap,
                                 input logic [SHIFT_W-1:0] shift);
      drain();
      write_reg(CSR_CHUNK_SIZE, CSR_DATA_W'(chunk));
      write_reg(CSR_HOLE_LIMIT, CSR_DATA_W'(limit));
      write_reg(CSR_MAX_DISTANCE, CSR_DATA_W'(reach));
      write_reg(CSR_SIZE_CAP, CSR_DATA_W'(cap));
      write_reg(CSR_PAGE_SHIFT, CSR_DATA_W'(shift));
      csr_wr_en <= 1'b0;
      cur_chunk = chunk;
      cur_limit = limit;
      settings_count++;
   endtask

   initial begin
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic [ADDR_W-1:0] eff_lo;
      logic [ADDR_W-1:0] span;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] chunk_eff;
      int                pick;
      int                sel;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b0;
      pressure_go = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, empty and reversed holes, low page, full table
      apply_settings(32'd4096, ADDR_TOP, ADDR_TOP, 32'd4096, 5'd12);
      offer(OP_CLEAR, ADDR_TOP, ADDR_TOP, ADDR_TOP);
      offer(OP_ALLOCATE, '0, '0, '0);
      offer(OP_ADD_HOLE, 48'h1234, 48'h1234, '0);
      offer(OP_ADD_HOLE, ADDR_TOP, '0, '0);
      offer(OP_ADD_HOLE, '0, 48'h3000, '0);
      offer(OP_ALLOCATE, '0, '0, '0);
      offer(OP_ALLOCATE, '0, '0, 48'h2FFF);
      offer(OP_NONE, ADDR_TOP, ADDR_TOP, ADDR_TOP);
      offer(OP_ADD_HOLE, '0, ADDR_TOP, '0);
      offer(OP_ADD_HOLE, 48'h10_0000, 48'h20_0000, '0);
      offer(OP_ALLOCATE, '0, '0, ADDR_TOP);
      offer(OP_CLEAR, '0, '0, '0);

      // zero hole limit, zero chunk size, size overflow at the largest page
      apply_settings(32'd0, 48'd0, 48'd0, 32'hFFFF_FFFF, 5'd21);
      offer(OP_ADD_HOLE, 48'h1000, 48'h2000, '0);
      apply_settings(32'd0, ADDR_TOP, 48'd0, 32'hFFFF_FFFF, 5'd21);
      offer(OP_ADD_HOLE, 48'h10_0000_0000, 48'h20_0000_0000, '0);
      offer(OP_ALLOCATE, '0, '0, 48'h10_0000_0001);
      offer(OP_ALLOCATE, '0, '0, 48'h10_0000_0000);
      offer(OP_ADD_HOLE, ADDR_TOP - 48'hFFFF, ADDR_TOP, '0);
      offer(OP_ALLOCATE, '0, '0, ADDR_TOP - 48'hFFFF);

      // short hole limit keeps only the top of a huge hole
      apply_settings(32'h8000_0000, 48'd4096, ADDR_TOP, 32'hFFFF_FFFF, 5'd12);
      offer(OP_ADD_HOLE, '0, 48'h100_0000_0000, '0);
      offer(OP_ALLOCATE, '0, '0, '0);
      offer(OP_ALLOCATE, '0, '0, ADDR_TOP);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:          apply_settings(CHUNK_SIZE_RST, HOLE_LIMIT_RST, MAX_DISTANCE_RST,
                                       SIZE_CAP_RST, PAGE_SHIFT_RST);
            1:          apply_settings(32'd4096, ADDR_TOP, ADDR_TOP, 32'd4096, 5'd12);
            PHASES - 1: apply_settings(32'h8000_0000, 48'd4096, 48'd0, 32'hFFFF_FFFF, 5'd21);
            default:    apply_settings(($urandom_range(9) == 0) ? 32'd0 :
                                          $urandom_range(32'h8000_0000, 4096),
                                       48'd4096 + rand_scaled(), rand_scaled(),
                                       $urandom_range(32'hFFFF_FFFF, 4096),
                                       SHIFT_W'($urandom_range(21, 12)));
         endcase
         calm = (p == 3);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == 10)
               pressure_go = 1'b1;
            pick = $urandom_range(99);
            if (pick < 8)
               offer(OP_CLEAR, rand48(), rand48(), rand48());
            else if (pick < 12)
               offer(OP_NONE, rand48(), rand48(), rand48());
            else if (pick < 45) begin
               chunk_eff = (cur_chunk == 0) ? 32'h0100_0000 : cur_chunk;
               sel = $urandom_range(9);
               lo = (sel < 5) ? rand48() : (sel < 8) ? rand_scaled() : ADDR_TOP - rand_scaled();
               if ($urandom_range(6) == 0)
                  hi = lo + rand_scaled();
               else
                  hi = lo + ADDR_W'(chunk_eff) * ADDR_W'($urandom_range(4, 0))
                          + ADDR_W'($urandom_range(chunk_eff, 1));
               if (hi < lo)
                  hi = ADDR_TOP;
               if ($urandom_range(9) == 0) begin
                  lo = rand48();
                  hi = rand48();
               end else if (hi > lo) begin
                  hole_lo_q.insert(hole_lo_q.size(), lo);
                  hole_hi_q.insert(hole_hi_q.size(), hi);
                  if (hole_lo_q.size() > 8) begin
                     void'(hole_lo_q.pop_front());
                     void'(hole_hi_q.pop_front());
                  end
               end
               offer(OP_ADD_HOLE, lo, hi, rand48());
            end else begin
               if (hole_lo_q.size() == 0 || $urandom_range(4) == 0)
                  addr = rand48();
               else begin
                  sel = $urandom_range(hole_lo_q.size() - 1);
                  lo = hole_lo_q[sel];
                  hi = hole_hi_q[sel];
                  eff_lo = (hi - lo > cur_limit) ? hi - cur_limit : lo;
                  span = hi - eff_lo;
                  if (span == 0)
                     span = 1;
                  case ($urandom_range(3))
                     0:       addr = eff_lo;
                     1, 2:    addr = eff_lo + rand48() % span;
                     default: addr = eff_lo + rand_scaled();
                  endcase
               end
               offer(OP_ALLOCATE, rand48(), rand48(), addr);
            end
         end
      end

      calm = 1'b0;
      drain();
      repeat (16) @(posedge clock);

      $display("ran %0d requests under %0d register settings in %0d cycles",
               items_sent, settings_count, cycle_count);
      $display("answers seen: %0d grants, %0d misses, %0d table full, %0d empty holes",
               grant_count, miss_count, full_count, empty_hole_count);
      if (fail_count == 0 && outstanding == 0)
         $display("** near_address_interval_allocator: PASSED **");
      else
         $display("** near_address_interval_allocator: FAILED **");
      $finish;
   end

endmodule
